/* rtl/pca_pkg.sv */
// ----------------------------------------------------------------------------
// pca_pkg
// Types and fixed constants for the pixel color adjustment pipeline.
// ----------------------------------------------------------------------------
package pca_pkg;

  // Operation select codes; code 7 passes the pixel through
  typedef enum logic [2:0] {
    MODE_BRIGHT_CONTRAST = 3'd0,
    MODE_COLORIZE        = 3'd1,
    MODE_DESATURATE      = 3'd2,
    MODE_POSTERIZE       = 3'd3,
    MODE_INVERT          = 3'd4,
    MODE_THRESHOLD       = 3'd5,
    MODE_ALPHA_THRESHOLD = 3'd6
  } mode_t;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_CONTRAST   = 3'd1;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [2:0] REG_TINT_RED   = 3'd3;
  localparam logic [2:0] REG_TINT_GREEN = 3'd4;
  localparam logic [2:0] REG_TINT_BLUE  = 3'd5;
  localparam logic [2:0] REG_POST_LVLS  = 3'd6;
  localparam logic [2:0] REG_THRESHOLD  = 3'd7;

  localparam int CFG_DATA_W = 17;
  localparam int CHAN_W     = 8;
  localparam int NUM_COLOR  = 3;

  // Contrast pivot and its Q8 offset
  localparam logic [9:0]  PIVOT     = 10'd127;
  localparam logic [21:0] PIVOT_Q8  = 22'd32512;
  localparam logic [7:0]  CHAN_MAX  = 8'd255;

  typedef logic [NUM_COLOR-1:0][CHAN_W-1:0] color_t;

endpackage

/* rtl/pixel_color_adjust.sv */
// ----------------------------------------------------------------------------
// pixel_color_adjust
// Point color adjustment of a straight ARGB pixel stream, one operation
// per image selected by the mode register.
// ----------------------------------------------------------------------------
// A new pixel is accepted every cycle unless an output stall holds the
// pipeline. Stage one registers gray and the contrast and posterize
// multiplier products, stage two adds brightness and forms tint products,
// the posterize quantized value and the threshold compares, stage three
// clamps, divides by 255, corrects the posterize estimate and selects by
// mode into the output register. A stall on the output holds the pipeline
// in place; empty stages still fill. The user writes configuration only while
// no pixel is in flight; the block does not enforce it. Register index 7 is last.
module pixel_color_adjust
  import pca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  mode_t              mode_r;
  logic signed [11:0] gain_r;
  logic signed [16:0] offset_r;
  color_t             tint_r;
  logic [8:0]         levels_r;
  logic [8:0]         thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BRIGHT_CONTRAST;
      gain_r    <= 12'sd256;
      offset_r  <= '0;
      tint_r[0] <= 8'd0;
      tint_r[1] <= 8'd0;
      tint_r[2] <= 8'd255;
      levels_r  <= 9'd4;
      thresh_r  <= 9'd128;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:       mode_r    <= mode_t'(cfg_wdata[2:0]);
        REG_CONTRAST:   gain_r    <= $signed(cfg_wdata[11:0]);
        REG_BRIGHTNESS: offset_r  <= $signed(cfg_wdata);
        REG_TINT_RED:   tint_r[0] <= cfg_wdata[7:0];
        REG_TINT_GREEN: tint_r[1] <= cfg_wdata[7:0];
        REG_TINT_BLUE:  tint_r[2] <= cfg_wdata[7:0];
        REG_POST_LVLS:  levels_r  <= cfg_wdata[8:0];
        REG_THRESHOLD:  thresh_r  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Posterize step and reciprocal tables, indexed by levels minus one
  // --------------------------------------------------------------------------
  logic [7:0]  step_tbl  [256];
  logic [16:0] recip_tbl [256];

  assign step_tbl[0]  = 8'd255;
  assign recip_tbl[0] = 17'd257;

  for (genvar d = 1; d < 256; d++) begin : g_post_tbl
    localparam int unsigned STEP_V  = 255 / d;
    localparam int unsigned RECIP_V = 65536 / STEP_V;
    assign step_tbl[d]  = 8'(STEP_V);
    assign recip_tbl[d] = 17'(RECIP_V);
  end

  // Clamp levels to 2..256 and form the table index
  logic [7:0]  post_idx;
  logic [7:0]  post_step;
  logic [16:0] post_recip;

  always_comb begin
    if (levels_r < 9'd2) begin
      post_idx = 8'd1;
    end else if (levels_r > 9'd256) begin
      post_idx = 8'd255;
    end else begin
      post_idx = 8'(levels_r - 9'd1);
    end
  end

  assign post_step  = step_tbl[post_idx];
  assign post_recip = recip_tbl[post_idx];

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it moves on
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_en, s2_en, s3_en;

  assign s3_en    = !s3_v_r || !out_stall;
  assign s2_en    = !s2_v_r || s3_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_valid;
      if (s2_en) s2_v_r <= s1_v_r;
      if (s3_en) s3_v_r <= s2_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: gray, contrast products, posterize reciprocal products
  // --------------------------------------------------------------------------
  color_t                   in_color;
  logic [12:0]              luma_sum;
  logic [7:0]               gray_nxt;
  logic signed [21:0]       bc_prod_nxt [NUM_COLOR];
  logic [7:0]               q_est_nxt   [NUM_COLOR];
  logic [24:0]              recip_prod  [NUM_COLOR];

  assign in_color = {in_blue, in_green, in_red};
  assign luma_sum = 13'(in_red) * 13'd11 + 13'(in_green) * 13'd16 + 13'(in_blue) * 13'd5;
  assign gray_nxt = luma_sum[12:5];

  always_comb begin
    for (int i = 0; i < NUM_COLOR; i++) begin
      bc_prod_nxt[i] = 22'($signed({2'b00, in_color[i]} - PIVOT)) * 22'(gain_r);
      recip_prod[i]  = 25'(in_color[i]) * 25'(post_recip);
      q_est_nxt[i]   = recip_prod[i][23:16];
    end
  end

  color_t             s1_color_r;
  logic [7:0]         s1_alpha_r;
  logic [7:0]         s1_gray_r;
  logic signed [21:0] s1_bc_prod_r [NUM_COLOR];
  logic [7:0]         s1_q_est_r   [NUM_COLOR];

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_color_r   <= in_color;
      s1_alpha_r   <= in_alpha;
      s1_gray_r    <= gray_nxt;
      s1_bc_prod_r <= bc_prod_nxt;
      s1_q_est_r   <= q_est_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: brightness sum, tint products, posterize estimate, compares
  // --------------------------------------------------------------------------
  logic signed [21:0] bc_sum_nxt  [NUM_COLOR];
  logic [15:0]        tint_nxt    [NUM_COLOR];
  logic [15:0]        post_prod   [NUM_COLOR];
  logic [7:0]         post_est_nxt[NUM_COLOR];

  always_comb begin
    for (int i = 0; i < NUM_COLOR; i++) begin
      bc_sum_nxt[i]   = s1_bc_prod_r[i] + $signed(PIVOT_Q8) + 22'(offset_r);
      tint_nxt[i]     = 16'(s1_gray_r) * 16'(tint_r[i]);
      post_prod[i]    = 16'(s1_q_est_r[i]) * 16'(post_step);
      post_est_nxt[i] = post_prod[i][7:0];
    end
  end

  color_t             s2_color_r;
  logic [7:0]         s2_alpha_r;
  logic [7:0]         s2_gray_r;
  logic signed [21:0] s2_bc_sum_r   [NUM_COLOR];
  logic [15:0]        s2_tint_r     [NUM_COLOR];
  logic [7:0]         s2_post_est_r [NUM_COLOR];
  logic               s2_gray_hi_r;
  logic               s2_alpha_hi_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_color_r    <= s1_color_r;
      s2_alpha_r    <= s1_alpha_r;
      s2_gray_r     <= s1_gray_r;
      s2_bc_sum_r   <= bc_sum_nxt;
      s2_tint_r     <= tint_nxt;
      s2_post_est_r <= post_est_nxt;
      s2_gray_hi_r  <= {1'b0, s1_gray_r} >= thresh_r;
      s2_alpha_hi_r <= {1'b0, s1_alpha_r} >= thresh_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp, divide by 255, correct posterize, select by mode
  // --------------------------------------------------------------------------
  color_t      bc_val;
  color_t      tint_val;
  color_t      post_val;
  logic [16:0] div_sum  [NUM_COLOR];
  logic [7:0]  post_rem [NUM_COLOR];
  color_t      color_nxt;
  logic [7:0]  alpha_nxt;

  always_comb begin
    for (int i = 0; i < NUM_COLOR; i++) begin
      // Truncated division by 256, clamped to 0..255
      if (s2_bc_sum_r[i][21]) begin
        bc_val[i] = 8'd0;
      end else if (s2_bc_sum_r[i][20:16] != 5'd0) begin
        bc_val[i] = CHAN_MAX;
      end else begin
        bc_val[i] = s2_bc_sum_r[i][15:8];
      end
      // Exact x / 255 for a 16-bit product
      div_sum[i]  = 17'(s2_tint_r[i]) + 17'(s2_tint_r[i][15:8]) + 17'd1;
      tint_val[i] = div_sum[i][15:8];
      // The estimate is at most one step low
      post_rem[i] = s2_color_r[i] - s2_post_est_r[i];
      post_val[i] = (post_rem[i] >= post_step) ? s2_post_est_r[i] + post_step
                                               : s2_post_est_r[i];
    end
  end

  always_comb begin
    color_nxt = s2_color_r;
    alpha_nxt = s2_alpha_r;
    case (mode_r)
      MODE_BRIGHT_CONTRAST: color_nxt = bc_val;
      MODE_COLORIZE:        color_nxt = tint_val;
      MODE_DESATURATE:      color_nxt = {NUM_COLOR{s2_gray_r}};
      MODE_POSTERIZE:       color_nxt = post_val;
      MODE_INVERT: begin
        color_nxt = ~s2_color_r;
        alpha_nxt = ~s2_alpha_r;
      end
      MODE_THRESHOLD:       color_nxt = {NUM_COLOR{{CHAN_W{s2_gray_hi_r}}}};
      MODE_ALPHA_THRESHOLD: alpha_nxt = {CHAN_W{s2_alpha_hi_r}};
      default: ;
    endcase
  end

  color_t     s3_color_r;
  logic [7:0] s3_alpha_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_color_r <= color_nxt;
      s3_alpha_r <= alpha_nxt;
    end
  end

  // Drive the result transfer
  assign out_valid = s3_v_r;
  assign out_red   = s3_color_r[0];
  assign out_green = s3_color_r[1];
  assign out_blue  = s3_color_r[2];
  assign out_alpha = s3_alpha_r;

endmodule

/* tb/sv/pixel_color_adjust_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_adjust_tb
// Self-checking bench for the pixel color adjustment block. A short directed
// table covers every mode and the register extremes. Random phases follow,
// each reprogramming every register and streaming random pixels. An internal
// predictor scores every result in order. Both handshakes idle and stall
// at random.
// ----------------------------------------------------------------------------
module pixel_color_adjust_tb
  import pca_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 40;
  localparam int N_PHASES    = 14;
  localparam int PHASE_ITEMS = 125;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [2:0]            idx;
    logic [CFG_DATA_W-1:0] data;
    pix_t                  px;
    pix_t                  want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_red    = 8'd0;
  logic [7:0]            in_green  = 8'd0;
  logic [7:0]            in_blue   = 8'd0;
  logic [7:0]            in_alpha  = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_alpha;

  // Shadow copy of the register file, at reset values
  logic [2:0]         cur_mode      = MODE_BRIGHT_CONTRAST;
  logic signed [11:0] cur_gain      = 12'sd256;
  logic signed [16:0] cur_offset    = 17'sd0;
  logic [7:0]         cur_tint_red  = 8'd0;
  logic [7:0]         cur_tint_green = 8'd0;
  logic [7:0]         cur_tint_blue = 8'd255;
  logic [8:0]         cur_levels    = 9'd4;
  logic [8:0]         cur_thresh    = 9'd128;

  pix_t pending_pixels[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  bit   quiet_stretch  = 1'b0;

  // Directed table; pixels are written as 0xRRGGBBAA
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h0CC84D63, 32'h0CC84D63},
    // most negative gain and offset
    '{ROW_CFG,       REG_CONTRAST,   17'h00800, 32'h00000000, 32'h00000000},
    '{ROW_CFG,       REG_BRIGHTNESS, 17'h10000, 32'h00000000, 32'h00000000},
    '{ROW_PIX,       REG_MODE,       17'h00000, 32'h00000000, 32'h00000000},
    '{ROW_PIX,       REG_MODE,       17'h00000, 32'hFFFFFFFF, 32'h00000000},
    // most positive gain and offset
    '{ROW_CFG,       REG_CONTRAST,   17'h007FF, 32'h00000000, 32'h00000000},
    '{ROW_CFG,       REG_BRIGHTNESS, 17'h0FFFF, 32'h00000000, 32'h00000000},
    '{ROW_PIX,       REG_MODE,       17'h00000, 32'h0080FF03, 32'h00000000},
    // zero gain collapses every channel to the pivot
    '{ROW_CFG,       REG_CONTRAST,   17'h00000, 32'h00000000, 32'h00000000},
    '{ROW_CFG,       REG_BRIGHTNESS, 17'h00000, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h0063FF28, 32'h7F7F7F28},
    '{ROW_CFG,       REG_MODE,       17'h00001, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFFFFFF42, 32'h0000FF42},
    '{ROW_PIX,       REG_MODE,       17'h00000, 32'hC8643201, 32'h00000000},
    '{ROW_CFG,       REG_MODE,       17'h00002, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFF00000A, 32'h5757570A},
    '{ROW_CFG,       REG_MODE,       17'h00003, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h5455FF07, 32'h0055FF07},
    // too few levels acts as two
    '{ROW_CFG,       REG_POST_LVLS,  17'h00000, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFEFF0008, 32'h00FF0008},
    // too many levels acts as 256, colors pass
    '{ROW_CFG,       REG_POST_LVLS,  17'h001FF, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFE018009, 32'hFE018009},
    '{ROW_CFG,       REG_MODE,       17'h00004, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h00FF11C8, 32'hFF00EE37},
    '{ROW_CFG,       REG_MODE,       17'h00005, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFFFFFF0B, 32'hFFFFFF0B},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h0000000C, 32'h0000000C},
    '{ROW_PIX,       REG_MODE,       17'h00000, 32'h827F7E0D, 32'h00000000},
    // threshold above 255 never matches
    '{ROW_CFG,       REG_THRESHOLD,  17'h001FF, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'hFFFFFF0E, 32'h0000000E},
    '{ROW_CFG,       REG_THRESHOLD,  17'h00000, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h0000000F, 32'hFFFFFF0F},
    '{ROW_CFG,       REG_MODE,       17'h00006, 32'h00000000, 32'h00000000},
    '{ROW_CFG,       REG_THRESHOLD,  17'h00080, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h0102037F, 32'h01020300},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h04050680, 32'h040506FF},
    // unused mode passes the pixel through
    '{ROW_CFG,       REG_MODE,       17'h00007, 32'h00000000, 32'h00000000},
    '{ROW_PIX_KNOWN, REG_MODE,       17'h00000, 32'h09080706, 32'h09080706}
  };

  pixel_color_adjust dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Brightness/contrast on one channel: scale about the pivot, round
  // toward zero, clamp
  function automatic logic [7:0] contrast_level(input logic [7:0] c);
    int t;
    t = (int'(c) - int'(PIVOT)) * int'(cur_gain) + int'(PIVOT_Q8) + int'(cur_offset);
    t = t / 256;
    if (t < 0) return 8'd0;
    if (t > 255) return CHAN_MAX;
    return 8'(t);
  endfunction

  function automatic pix_t predict_pixel(input pix_t px);
    pix_t res;
    int   gray;
    int   lv;
    int   step;
    res  = px;
    gray = (int'(px.red) * 11 + int'(px.green) * 16 + int'(px.blue) * 5) / 32;
    case (cur_mode)
      MODE_BRIGHT_CONTRAST: begin
        res.red   = contrast_level(px.red);
        res.green = contrast_level(px.green);
        res.blue  = contrast_level(px.blue);
      end
      MODE_COLORIZE: begin
        res.red   = 8'(gray * int'(cur_tint_red) / 255);
        res.green = 8'(gray * int'(cur_tint_green) / 255);
        res.blue  = 8'(gray * int'(cur_tint_blue) / 255);
      end
      MODE_DESATURATE: begin
        res.red   = 8'(gray);
        res.green = 8'(gray);
        res.blue  = 8'(gray);
      end
      MODE_POSTERIZE: begin
        lv = int'(cur_levels);
        if (lv < 2) lv = 2;
        if (lv > 256) lv = 256;
        step      = 255 / (lv - 1);
        res.red   = 8'((int'(px.red) / step) * step);
        res.green = 8'((int'(px.green) / step) * step);
        res.blue  = 8'((int'(px.blue) / step) * step);
      end
      MODE_INVERT: begin
        res.red   = CHAN_MAX - px.red;
        res.green = CHAN_MAX - px.green;
        res.blue  = CHAN_MAX - px.blue;
        res.alpha = CHAN_MAX - px.alpha;
      end
      MODE_THRESHOLD: begin
        res.red   = (gray >= int'(cur_thresh)) ? CHAN_MAX : 8'd0;
        res.green = res.red;
        res.blue  = res.red;
      end
      MODE_ALPHA_THRESHOLD: begin
        res.alpha = (int'(px.alpha) >= int'(cur_thresh)) ? CHAN_MAX : 8'd0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Drive one register write and track it in the shadow copy
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE:       cur_mode       = val[2:0];
      REG_CONTRAST:   cur_gain       = val[11:0];
      REG_BRIGHTNESS: cur_offset     = val[16:0];
      REG_TINT_RED:   cur_tint_red   = val[7:0];
      REG_TINT_GREEN: cur_tint_green = val[7:0];
      REG_TINT_BLUE:  cur_tint_blue  = val[7:0];
      REG_POST_LVLS:  cur_levels     = val[8:0];
      REG_THRESHOLD:  cur_thresh     = val[8:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding pixel to come back
  task automatic hold_until_drained();
    in_valid  <= 1'b0;
    cfg_wr_en <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Offer one pixel, hold it until the transfer, then queue its result
  task automatic send_pixel(input pix_t px, input logic known, input pix_t want);
    if (!quiet_stretch) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    in_alpha <= px.alpha;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(known ? want : predict_pixel(px));
  endtask

  task automatic note_mismatch(input string what, input pix_t want, input pix_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
               $time, what, want.red, want.green, want.blue, want.alpha,
               got.red, got.green, got.blue, got.alpha);
    end
  endtask

  // Output stall: random, except during the quiet stretch
  always @(posedge clk) begin
    if (quiet_stretch) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 9);
    end
  end

  // Score each result transfer against the oldest expectation
  always @(posedge clk) begin
    pix_t got;
    pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_red, out_green, out_blue, out_alpha};
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", '0, got);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red != want.red || got.green != want.green ||
            got.blue != want.blue || got.alpha != want.alpha) begin
          note_mismatch("pixel mismatch", want, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t             row;
    pix_t                  px;
    logic [CFG_DATA_W-1:0] val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        hold_until_drained();
        write_reg(row.idx, row.data);
      end else begin
        cfg_wr_en <= 1'b0;
        send_pixel(row.px, row.kind == ROW_PIX_KNOWN, row.want);
      end
    end

    // Random phases: reprogram every register, then stream pixels
    for (int ph = 0; ph < N_PHASES; ph++) begin
      hold_until_drained();
      quiet_stretch = (ph == 5);
      write_reg(REG_MODE, (ph < 8) ? 17'(ph) : 17'($urandom_range(0, 7)));
      case ($urandom_range(0, 4))
        0: val = 17'h00800;
        1: val = 17'h007FF;
        2: val = 17'd256;
        3: val = 17'($urandom_range(64, 640));
        default: val = 17'($urandom);
      endcase
      write_reg(REG_CONTRAST, val);
      case ($urandom_range(0, 4))
        0: val = 17'h10000;
        1: val = 17'h0FFFF;
        2: val = 17'd0;
        3: val = 17'($urandom_range(0, 16383)) - 17'd8192;
        default: val = 17'($urandom);
      endcase
      write_reg(REG_BRIGHTNESS, val);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: val = 17'd0;
          1: val = 17'd255;
          default: val = 17'($urandom_range(0, 255));
        endcase
        write_reg(3'(REG_TINT_RED + k), val);
      end
      case ($urandom_range(0, 7))
        0: val = 17'd0;
        1: val = 17'd1;
        2: val = 17'd2;
        3: val = 17'd256;
        4: val = 17'd511;
        5, 6: val = 17'($urandom_range(3, 17));
        default: val = 17'($urandom_range(0, 511));
      endcase
      write_reg(REG_POST_LVLS, val);
      case ($urandom_range(0, 5))
        0: val = 17'd0;
        1: val = 17'd255;
        2: val = 17'd256;
        3: val = 17'd511;
        default: val = 17'($urandom_range(0, 256));
      endcase
      write_reg(REG_THRESHOLD, val);
      cfg_wr_en <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause the source mid-phase until the pipeline is empty
        if (ph == 3 && n == PHASE_ITEMS / 2) hold_until_drained();
        px = '{rand_chan(), rand_chan(), rand_chan(), rand_chan()};
        send_pixel(px, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
